>>> src/i2cra_pkg.sv
// shared types and constants for the i2c register access master
package i2cra_pkg;

	// hold counter width and saturation limit
	localparam int WAIT_W = 16;
	localparam logic [32:0] WAIT_MAX = (33'd1 << WAIT_W) - 33'd1;

	// command codes carried on tuser
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_DEV_ADDR = 2'd0;
	localparam logic [1:0] CFG_HALF_PER = 2'd1;

	// reset values of the configuration registers
	localparam logic [6:0]  DEV_ADDR_RST = 7'd42;
	localparam logic [15:0] HALF_PER_RST = 16'd100;

	// byte positions within a transaction
	localparam logic [2:0] BYTE_ADDR_W  = 3'd0;
	localparam logic [2:0] BYTE_REG_HI  = 3'd1;
	localparam logic [2:0] BYTE_REG_LO  = 3'd2;
	localparam logic [2:0] BYTE_VAL_HI  = 3'd3;
	localparam logic [2:0] BYTE_VAL_LO  = 3'd4;
	localparam logic [2:0] BYTE_ADDR_R  = 3'd3;
	localparam logic [2:0] BYTE_RD_HI   = 3'd4;
	localparam logic [2:0] BYTE_RD_LO   = 3'd5;

	// bits per byte on the bus
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// bus sequencer phases
	typedef enum logic [4:0] {
		PH_IDLE         = 5'd0,
		PH_START_SDA_HI = 5'd1,
		PH_START_SCL_HI = 5'd2,
		PH_START_SDA_LO = 5'd3,
		PH_START_SCL_LO = 5'd4,
		PH_START_GAP    = 5'd5,
		PH_TX_DATA      = 5'd6,
		PH_TX_SCL_HI    = 5'd7,
		PH_TX_SCL_LO    = 5'd8,
		PH_TX_ACK_REL   = 5'd9,
		PH_TX_ACK_HI    = 5'd10,
		PH_TX_ACK_LO    = 5'd11,
		PH_RX_REL       = 5'd12,
		PH_RX_SCL_HI    = 5'd13,
		PH_RX_GAP       = 5'd14,
		PH_RX_SCL_LO    = 5'd15,
		PH_RX_ACK_DRV   = 5'd16,
		PH_RX_ACK_HI    = 5'd17,
		PH_RX_ACK_LO    = 5'd18,
		PH_RX_END       = 5'd19,
		PH_STOP_SDA_LO  = 5'd20,
		PH_STOP_SCL_HI  = 5'd21,
		PH_STOP_SDA_HI  = 5'd22,
		PH_STOP_GAP     = 5'd23,
		PH_FINISH       = 5'd24
	} phase_t;

	// one tick of input
	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] reg_address;
		logic [15:0] write_value;
		logic        sda_sample;
	} tick_in_t;

	// one tick of result
	typedef struct packed {
		logic        scl_level;
		logic        sda_level;
		logic        busy_res;
		logic        done_res;
		logic        ack_ok;
		logic [15:0] read_word;
	} tick_res_t;

	// configuration seen by the sequencer
	typedef struct packed {
		logic [6:0]  device_address;
		logic [15:0] half_period_ticks;
	} cfg_t;

endpackage

>>> src/i2c_register_access_master.sv
// top level of the i2c register access master: stream ports, config and output register
//
// Each input word on the s_ group is one tick of the bus timebase. The block
// bit-bangs an open-drain I2C master: an opcode of write starts a 16-bit
// register write (start, address+W, register address, value, stop), an
// opcode of read starts a 16-bit register read (start, address+W, register
// address, repeated start, address+R, two bytes read, stop). Commands are
// taken only on a tick that begins idle; other ticks just advance the bus.
// Every input word produces exactly one output word on the m_ group with the
// pin levels, busy, done, ack status and read word for that tick.
// Each output word is registered and shows in the cycle after its input is accepted.
// One word per cycle unless m_tready stalls it, set by the sequencer's next-state pass.
// The output register is refilled in the cycle it is drained, so s_tready
// drops only while a result waits and m_tready is low.
// Configuration writes on cfg_ (index 0 device address, 1 half period ticks)
// are always ready and should be issued while idle.
// Reset puts the sequencer idle with both lines released, device address 42,
// half period 100, and empties the output register.
module i2c_register_access_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // reg_address[15:0], write_value[31:16], sda_sample[32]
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // scl_level[0], sda_level[1], busy_res[2], done_res[3],
	                              // ack_ok[4], read_word[20:5]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	i2cra_pkg::cfg_t      cfg_q;
	i2cra_pkg::tick_in_t  tick_in;
	i2cra_pkg::tick_res_t tick_res;
	logic                 accept;
	logic                 m_tvalid_q;
	logic [23:0]          m_tdata_q;

	// handshake: take a word whenever the output register is free or draining
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// unpack the input word
	always_comb begin
		tick_in.opcode = s_tuser;
		tick_in.reg_address = s_tdata[15:0];
		tick_in.write_value = s_tdata[31:16];
		tick_in.sda_sample = s_tdata[32];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= i2cra_pkg::DEV_ADDR_RST;
			cfg_q.half_period_ticks <= i2cra_pkg::HALF_PER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				i2cra_pkg::CFG_DEV_ADDR: cfg_q.device_address <= cfg_data[6:0];
				i2cra_pkg::CFG_HALF_PER: cfg_q.half_period_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// bus sequencer
	i2cra_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (accept),
		.tick_in  (tick_in),
		.cfg      (cfg_q),
		.tick_res (tick_res)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {3'b000, tick_res.read_word, tick_res.ack_ok, tick_res.done_res,
				tick_res.busy_res, tick_res.sda_level, tick_res.scl_level};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

>>> src/i2cra_core.sv
// bus sequencer state and per-tick next-state logic
module i2cra_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  i2cra_pkg::tick_in_t   tick_in,
	input  i2cra_pkg::cfg_t       cfg,
	output i2cra_pkg::tick_res_t  tick_res
);

	typedef struct packed {
		i2cra_pkg::phase_t phase;
		logic [7:0]        shift_byte;
		logic [3:0]        bit_count;
	} item_sel_t;

	i2cra_pkg::phase_t phase_q, n_phase;
	logic [3:0]  bit_count_q, n_bit;
	logic [2:0]  byte_index_q, n_byte;
	logic [7:0]  shift_byte_q, n_shift;
	logic [i2cra_pkg::WAIT_W-1:0] wait_q, n_wait, wait_load;
	logic        ack_q, n_ack;
	logic        is_read_q, n_is_read;
	logic [15:0] held_addr_q, n_haddr;
	logic [15:0] held_val_q, n_hval;
	logic [15:0] rx_word_q, n_rx;
	logic        scl_q, n_scl;
	logic        sda_q, n_sda;
	logic        n_done;
	logic [15:0] hp_eff;
	logic [15:0] hp_m1;
	item_sel_t   nxt;

	// pick the next byte to send or receive
	function automatic item_sel_t next_item(input logic [2:0] n, input logic rd,
		input logic [6:0] dev, input logic [15:0] haddr, input logic [15:0] hval,
		input logic [7:0] cur_shift, input logic [3:0] cur_bit);
		item_sel_t r;
		logic [7:0] addr_w;
		addr_w = {dev, 1'b0};
		r.phase = i2cra_pkg::PH_TX_DATA;
		r.shift_byte = cur_shift;
		r.bit_count = 4'd0;
		if (n == i2cra_pkg::BYTE_ADDR_W) begin
			r.shift_byte = addr_w;
		end else if (n == i2cra_pkg::BYTE_REG_HI) begin
			r.shift_byte = haddr[15:8];
		end else if (n == i2cra_pkg::BYTE_REG_LO) begin
			r.shift_byte = haddr[7:0];
		end else if (!rd) begin
			if (n == i2cra_pkg::BYTE_VAL_HI) begin
				r.shift_byte = hval[15:8];
			end else if (n == i2cra_pkg::BYTE_VAL_LO) begin
				r.shift_byte = hval[7:0];
			end else begin
				r.phase = i2cra_pkg::PH_STOP_SDA_LO;
				r.bit_count = cur_bit;
			end
		end else begin
			if (n == i2cra_pkg::BYTE_ADDR_R) begin
				r.shift_byte = addr_w | 8'h01;
			end else if (n == i2cra_pkg::BYTE_RD_HI || n == i2cra_pkg::BYTE_RD_LO) begin
				r.shift_byte = 8'h00;
				r.phase = i2cra_pkg::PH_RX_REL;
			end else begin
				r.phase = i2cra_pkg::PH_STOP_SDA_LO;
				r.bit_count = cur_bit;
			end
		end
		return r;
	endfunction

	// hold length after a pin change, zero half period acts as one
	always_comb begin
		hp_eff = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
		hp_m1 = hp_eff - 16'd1;
		if (33'(hp_m1) > i2cra_pkg::WAIT_MAX) begin
			wait_load = i2cra_pkg::WAIT_MAX[i2cra_pkg::WAIT_W-1:0];
		end else begin
			wait_load = i2cra_pkg::WAIT_W'(hp_m1);
		end
	end

	// next state of the sequencer for this tick
	always_comb begin
		n_phase = phase_q;
		n_bit = bit_count_q;
		n_byte = byte_index_q;
		n_shift = shift_byte_q;
		n_wait = wait_q;
		n_ack = ack_q;
		n_is_read = is_read_q;
		n_haddr = held_addr_q;
		n_hval = held_val_q;
		n_rx = rx_word_q;
		n_scl = scl_q;
		n_sda = sda_q;
		n_done = 1'b0;
		nxt = '0;

		// command accepted only when idle
		if (phase_q == i2cra_pkg::PH_IDLE &&
			(tick_in.opcode == i2cra_pkg::OP_WRITE || tick_in.opcode == i2cra_pkg::OP_READ)) begin
			n_is_read = (tick_in.opcode == i2cra_pkg::OP_READ);
			n_haddr = tick_in.reg_address;
			n_hval = tick_in.write_value;
			n_byte = 3'd0;
			n_bit = 4'd0;
			n_shift = 8'd0;
			n_ack = 1'b1;
			n_rx = 16'd0;
			n_wait = '0;
			n_phase = i2cra_pkg::PH_START_SDA_HI;
		end

		if (n_phase != i2cra_pkg::PH_IDLE) begin
			if (n_wait != '0) begin
				n_wait = n_wait - i2cra_pkg::WAIT_W'(1);
			end else begin
				n_wait = wait_load;
				case (n_phase)
					i2cra_pkg::PH_START_SDA_HI: begin
						n_sda = 1'b1; n_phase = i2cra_pkg::PH_START_SCL_HI;
					end
					i2cra_pkg::PH_START_SCL_HI: begin
						n_scl = 1'b1; n_phase = i2cra_pkg::PH_START_SDA_LO;
					end
					i2cra_pkg::PH_START_SDA_LO: begin
						n_sda = 1'b0; n_phase = i2cra_pkg::PH_START_SCL_LO;
					end
					i2cra_pkg::PH_START_SCL_LO: begin
						n_scl = 1'b0; n_phase = i2cra_pkg::PH_START_GAP;
					end
					i2cra_pkg::PH_START_GAP: begin
						nxt = next_item(n_byte, n_is_read, cfg.device_address, n_haddr,
							n_hval, n_shift, n_bit);
						n_phase = nxt.phase; n_shift = nxt.shift_byte; n_bit = nxt.bit_count;
					end
					i2cra_pkg::PH_TX_DATA: begin
						n_sda = n_shift[7]; n_phase = i2cra_pkg::PH_TX_SCL_HI;
					end
					i2cra_pkg::PH_TX_SCL_HI: begin
						n_scl = 1'b1; n_phase = i2cra_pkg::PH_TX_SCL_LO;
					end
					i2cra_pkg::PH_TX_SCL_LO: begin
						n_scl = 1'b0;
						n_shift = {n_shift[6:0], 1'b0};
						n_bit = n_bit + 4'd1;
						n_phase = (n_bit >= i2cra_pkg::BITS_PER_BYTE) ?
							i2cra_pkg::PH_TX_ACK_REL : i2cra_pkg::PH_TX_DATA;
					end
					i2cra_pkg::PH_TX_ACK_REL: begin
						n_sda = 1'b1; n_phase = i2cra_pkg::PH_TX_ACK_HI;
					end
					i2cra_pkg::PH_TX_ACK_HI: begin
						n_scl = 1'b1; n_phase = i2cra_pkg::PH_TX_ACK_LO;
					end
					i2cra_pkg::PH_TX_ACK_LO: begin
						if (tick_in.sda_sample) n_ack = 1'b0;
						n_scl = 1'b0;
						n_byte = n_byte + 3'd1;
						if (n_is_read && n_byte == i2cra_pkg::BYTE_ADDR_R) begin
							n_phase = i2cra_pkg::PH_START_SDA_HI;
						end else begin
							nxt = next_item(n_byte, n_is_read, cfg.device_address, n_haddr,
								n_hval, n_shift, n_bit);
							n_phase = nxt.phase; n_shift = nxt.shift_byte; n_bit = nxt.bit_count;
						end
					end
					i2cra_pkg::PH_RX_REL: begin
						n_sda = 1'b1; n_phase = i2cra_pkg::PH_RX_SCL_HI;
					end
					i2cra_pkg::PH_RX_SCL_HI: begin
						n_scl = 1'b1; n_phase = i2cra_pkg::PH_RX_GAP;
					end
					i2cra_pkg::PH_RX_GAP: begin
						n_phase = i2cra_pkg::PH_RX_SCL_LO;
					end
					i2cra_pkg::PH_RX_SCL_LO: begin
						n_shift = {n_shift[6:0], tick_in.sda_sample};
						n_scl = 1'b0;
						n_bit = n_bit + 4'd1;
						n_phase = (n_bit >= i2cra_pkg::BITS_PER_BYTE) ?
							i2cra_pkg::PH_RX_ACK_DRV : i2cra_pkg::PH_RX_SCL_HI;
					end
					i2cra_pkg::PH_RX_ACK_DRV: begin
						// ack the first byte, nack the second
						n_sda = (n_byte == i2cra_pkg::BYTE_RD_HI) ? 1'b0 : 1'b1;
						n_phase = i2cra_pkg::PH_RX_ACK_HI;
					end
					i2cra_pkg::PH_RX_ACK_HI: begin
						n_scl = 1'b1; n_phase = i2cra_pkg::PH_RX_ACK_LO;
					end
					i2cra_pkg::PH_RX_ACK_LO: begin
						n_scl = 1'b0; n_phase = i2cra_pkg::PH_RX_END;
					end
					i2cra_pkg::PH_RX_END: begin
						n_sda = 1'b1;
						if (n_byte == i2cra_pkg::BYTE_RD_HI) begin
							n_rx = {n_shift, n_rx[7:0]};
						end else begin
							n_rx = {n_rx[15:8], n_shift};
						end
						n_byte = n_byte + 3'd1;
						nxt = next_item(n_byte, n_is_read, cfg.device_address, n_haddr,
							n_hval, n_shift, n_bit);
						n_phase = nxt.phase; n_shift = nxt.shift_byte; n_bit = nxt.bit_count;
					end
					i2cra_pkg::PH_STOP_SDA_LO: begin
						n_sda = 1'b0; n_phase = i2cra_pkg::PH_STOP_SCL_HI;
					end
					i2cra_pkg::PH_STOP_SCL_HI: begin
						n_scl = 1'b1; n_phase = i2cra_pkg::PH_STOP_SDA_HI;
					end
					i2cra_pkg::PH_STOP_SDA_HI: begin
						n_sda = 1'b1; n_phase = i2cra_pkg::PH_STOP_GAP;
					end
					i2cra_pkg::PH_STOP_GAP: begin
						n_phase = i2cra_pkg::PH_FINISH;
					end
					i2cra_pkg::PH_FINISH: begin
						n_phase = i2cra_pkg::PH_IDLE;
						n_wait = '0;
						n_done = 1'b1;
					end
					default: begin
						// unknown phase code: back to idle, lines released
						n_phase = i2cra_pkg::PH_IDLE;
						n_scl = 1'b1;
						n_sda = 1'b1;
						n_wait = '0;
					end
				endcase
			end
		end
	end

	// result of this tick
	always_comb begin
		tick_res.scl_level = n_scl;
		tick_res.sda_level = n_sda;
		tick_res.busy_res = (n_phase != i2cra_pkg::PH_IDLE);
		tick_res.done_res = n_done;
		tick_res.ack_ok = n_done & n_ack;
		tick_res.read_word = (n_done && n_is_read) ? n_rx : 16'd0;
	end

	// sequencer state, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cra_pkg::PH_IDLE;
			bit_count_q <= 4'd0;
			byte_index_q <= 3'd0;
			shift_byte_q <= 8'd0;
			wait_q <= '0;
			ack_q <= 1'b1;
			is_read_q <= 1'b0;
			held_addr_q <= 16'd0;
			held_val_q <= 16'd0;
			rx_word_q <= 16'd0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
		end else if (step) begin
			phase_q <= n_phase;
			bit_count_q <= n_bit;
			byte_index_q <= n_byte;
			shift_byte_q <= n_shift;
			wait_q <= n_wait;
			ack_q <= n_ack;
			is_read_q <= n_is_read;
			held_addr_q <= n_haddr;
			held_val_q <= n_hval;
			rx_word_q <= n_rx;
			scl_q <= n_scl;
			sda_q <= n_sda;
		end
	end

endmodule

>>> tb/i2cra_checker.sv
// checker for the i2c register access master: bus sequencer prediction and result compare
module i2cra_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,  // reg_address[15:0], write_value[31:16], sda_sample[32]
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,  // scl_level[0], sda_level[1], busy_res[2], done_res[3],
	                              // ack_ok[4], read_word[20:5]
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        end_check,
	output int          fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// predicted configuration
	logic [6:0]        dev_addr;
	logic [15:0]       half_per;

	// predicted sequencer state
	i2cra_pkg::phase_t seq_phase;
	logic [3:0]        bits_done;
	logic [2:0]        byte_pos;
	logic [7:0]        shreg;
	logic [i2cra_pkg::WAIT_W-1:0] hold_cnt;
	logic              all_acked;
	logic              rd_mode;
	logic [15:0]       cmd_addr;
	logic [15:0]       cmd_val;
	logic [15:0]       rd_word;
	logic              scl_drv;
	logic              sda_drv;

	// expected output words, oldest first
	i2cra_pkg::tick_res_t tick_levels_q[$];
	int unsigned       res_idx;
	logic              end_seen;

	task automatic flag_error(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_field(string name, int unsigned got, int unsigned want);
		if (got != want)
			flag_error($sformatf("word %0d %s got %0h want %0h", res_idx, name, got, want));
	endtask

	// hold after a pin change, zero half period acts as one, saturates at the counter width
	function automatic logic [i2cra_pkg::WAIT_W-1:0] hold_ticks();
		logic [32:0] span;
		span = (half_per == 16'd0) ? 33'd0 : {17'd0, half_per} - 33'd1;
		if (span > i2cra_pkg::WAIT_MAX)
			span = i2cra_pkg::WAIT_MAX;
		return span[i2cra_pkg::WAIT_W-1:0];
	endfunction

	function automatic void load_byte(logic [7:0] b);
		shreg = b;
		bits_done = 4'd0;
		seq_phase = i2cra_pkg::PH_TX_DATA;
	endfunction

	// pick the next byte of the transaction, or the stop
	function automatic void next_byte();
		logic [7:0] addr_w;
		addr_w = {dev_addr, 1'b0};
		if (byte_pos == i2cra_pkg::BYTE_ADDR_W) begin
			load_byte(addr_w);
		end else if (byte_pos == i2cra_pkg::BYTE_REG_HI) begin
			load_byte(cmd_addr[15:8]);
		end else if (byte_pos == i2cra_pkg::BYTE_REG_LO) begin
			load_byte(cmd_addr[7:0]);
		end else if (!rd_mode) begin
			if (byte_pos == i2cra_pkg::BYTE_VAL_HI)
				load_byte(cmd_val[15:8]);
			else if (byte_pos == i2cra_pkg::BYTE_VAL_LO)
				load_byte(cmd_val[7:0]);
			else
				seq_phase = i2cra_pkg::PH_STOP_SDA_LO;
		end else begin
			if (byte_pos == i2cra_pkg::BYTE_ADDR_R) begin
				load_byte(addr_w | 8'h01);
			end else if (byte_pos == i2cra_pkg::BYTE_RD_HI ||
				byte_pos == i2cra_pkg::BYTE_RD_LO) begin
				shreg = 8'd0;
				bits_done = 4'd0;
				seq_phase = i2cra_pkg::PH_RX_REL;
			end else begin
				seq_phase = i2cra_pkg::PH_STOP_SDA_LO;
			end
		end
	endfunction

	// one pin action of the sequencer, returns high on the finishing tick
	function automatic logic pin_action(logic sda_in);
		logic reload;
		logic fin;
		reload = 1'b1;
		fin = 1'b0;
		case (seq_phase)
			i2cra_pkg::PH_START_SDA_HI: begin
				sda_drv = 1'b1; seq_phase = i2cra_pkg::PH_START_SCL_HI;
			end
			i2cra_pkg::PH_START_SCL_HI: begin
				scl_drv = 1'b1; seq_phase = i2cra_pkg::PH_START_SDA_LO;
			end
			i2cra_pkg::PH_START_SDA_LO: begin
				sda_drv = 1'b0; seq_phase = i2cra_pkg::PH_START_SCL_LO;
			end
			i2cra_pkg::PH_START_SCL_LO: begin
				scl_drv = 1'b0; seq_phase = i2cra_pkg::PH_START_GAP;
			end
			i2cra_pkg::PH_START_GAP: next_byte();
			i2cra_pkg::PH_TX_DATA: begin
				sda_drv = shreg[7]; seq_phase = i2cra_pkg::PH_TX_SCL_HI;
			end
			i2cra_pkg::PH_TX_SCL_HI: begin
				scl_drv = 1'b1; seq_phase = i2cra_pkg::PH_TX_SCL_LO;
			end
			i2cra_pkg::PH_TX_SCL_LO: begin
				scl_drv = 1'b0;
				shreg = {shreg[6:0], 1'b0};
				bits_done = bits_done + 4'd1;
				seq_phase = (bits_done >= i2cra_pkg::BITS_PER_BYTE) ?
					i2cra_pkg::PH_TX_ACK_REL : i2cra_pkg::PH_TX_DATA;
			end
			i2cra_pkg::PH_TX_ACK_REL: begin
				sda_drv = 1'b1; seq_phase = i2cra_pkg::PH_TX_ACK_HI;
			end
			i2cra_pkg::PH_TX_ACK_HI: begin
				scl_drv = 1'b1; seq_phase = i2cra_pkg::PH_TX_ACK_LO;
			end
			i2cra_pkg::PH_TX_ACK_LO: begin
				// a released data line here is a nack
				if (sda_in)
					all_acked = 1'b0;
				scl_drv = 1'b0;
				byte_pos = byte_pos + 3'd1;
				if (rd_mode && byte_pos == i2cra_pkg::BYTE_ADDR_R)
					seq_phase = i2cra_pkg::PH_START_SDA_HI;
				else
					next_byte();
			end
			i2cra_pkg::PH_RX_REL: begin
				sda_drv = 1'b1; seq_phase = i2cra_pkg::PH_RX_SCL_HI;
			end
			i2cra_pkg::PH_RX_SCL_HI: begin
				scl_drv = 1'b1; seq_phase = i2cra_pkg::PH_RX_GAP;
			end
			i2cra_pkg::PH_RX_GAP: seq_phase = i2cra_pkg::PH_RX_SCL_LO;
			i2cra_pkg::PH_RX_SCL_LO: begin
				shreg = {shreg[6:0], sda_in};
				scl_drv = 1'b0;
				bits_done = bits_done + 4'd1;
				seq_phase = (bits_done >= i2cra_pkg::BITS_PER_BYTE) ?
					i2cra_pkg::PH_RX_ACK_DRV : i2cra_pkg::PH_RX_SCL_HI;
			end
			i2cra_pkg::PH_RX_ACK_DRV: begin
				// ack the first byte read, nack the second
				sda_drv = (byte_pos == i2cra_pkg::BYTE_RD_HI) ? 1'b0 : 1'b1;
				seq_phase = i2cra_pkg::PH_RX_ACK_HI;
			end
			i2cra_pkg::PH_RX_ACK_HI: begin
				scl_drv = 1'b1; seq_phase = i2cra_pkg::PH_RX_ACK_LO;
			end
			i2cra_pkg::PH_RX_ACK_LO: begin
				scl_drv = 1'b0; seq_phase = i2cra_pkg::PH_RX_END;
			end
			i2cra_pkg::PH_RX_END: begin
				sda_drv = 1'b1;
				if (byte_pos == i2cra_pkg::BYTE_RD_HI)
					rd_word[15:8] = shreg;
				else
					rd_word[7:0] = shreg;
				byte_pos = byte_pos + 3'd1;
				next_byte();
			end
			i2cra_pkg::PH_STOP_SDA_LO: begin
				sda_drv = 1'b0; seq_phase = i2cra_pkg::PH_STOP_SCL_HI;
			end
			i2cra_pkg::PH_STOP_SCL_HI: begin
				scl_drv = 1'b1; seq_phase = i2cra_pkg::PH_STOP_SDA_HI;
			end
			i2cra_pkg::PH_STOP_SDA_HI: begin
				sda_drv = 1'b1; seq_phase = i2cra_pkg::PH_STOP_GAP;
			end
			i2cra_pkg::PH_STOP_GAP: seq_phase = i2cra_pkg::PH_FINISH;
			i2cra_pkg::PH_FINISH: begin
				seq_phase = i2cra_pkg::PH_IDLE;
				hold_cnt = '0;
				reload = 1'b0;
				fin = 1'b1;
			end
			default: begin
				// undefined phase code falls back to idle with the lines released
				seq_phase = i2cra_pkg::PH_IDLE;
				scl_drv = 1'b1;
				sda_drv = 1'b1;
				hold_cnt = '0;
				reload = 1'b0;
			end
		endcase
		if (reload)
			hold_cnt = hold_ticks();
		return fin;
	endfunction

	// advance the bus by one tick and give the expected output word
	function automatic i2cra_pkg::tick_res_t advance_bus(i2cra_pkg::tick_in_t t);
		i2cra_pkg::tick_res_t r;
		logic      fin;
		fin = 1'b0;
		if (seq_phase == i2cra_pkg::PH_IDLE &&
			(t.opcode == i2cra_pkg::OP_WRITE || t.opcode == i2cra_pkg::OP_READ)) begin
			rd_mode = (t.opcode == i2cra_pkg::OP_READ);
			cmd_addr = t.reg_address;
			cmd_val = t.write_value;
			byte_pos = 3'd0;
			bits_done = 4'd0;
			shreg = 8'd0;
			all_acked = 1'b1;
			rd_word = 16'd0;
			hold_cnt = '0;
			seq_phase = i2cra_pkg::PH_START_SDA_HI;
		end
		if (seq_phase != i2cra_pkg::PH_IDLE) begin
			if (hold_cnt != '0)
				hold_cnt = hold_cnt - i2cra_pkg::WAIT_W'(1);
			else
				fin = pin_action(t.sda_sample);
		end
		r.scl_level = scl_drv;
		r.sda_level = sda_drv;
		r.busy_res = (seq_phase != i2cra_pkg::PH_IDLE);
		r.done_res = fin;
		r.ack_ok = fin & all_acked;
		r.read_word = (fin && rd_mode) ? rd_word : 16'd0;
		return r;
	endfunction

	// watch the channels, predict and compare
	always @(posedge clk or negedge arst_n) begin
		i2cra_pkg::tick_in_t  t_in;
		i2cra_pkg::tick_res_t got;
		i2cra_pkg::tick_res_t want;
		if (!arst_n) begin
			dev_addr = i2cra_pkg::DEV_ADDR_RST;
			half_per = i2cra_pkg::HALF_PER_RST;
			seq_phase = i2cra_pkg::PH_IDLE;
			bits_done = 4'd0;
			byte_pos = 3'd0;
			shreg = 8'd0;
			hold_cnt = '0;
			all_acked = 1'b1;
			rd_mode = 1'b0;
			cmd_addr = 16'd0;
			cmd_val = 16'd0;
			rd_word = 16'd0;
			scl_drv = 1'b1;
			sda_drv = 1'b1;
			tick_levels_q.delete();
			res_idx = 0;
			end_seen = 1'b0;
			fail_count = 0;
		end else begin
			// output words against the oldest prediction
			if (m_tvalid && m_tready) begin
				got.scl_level = m_tdata[0];
				got.sda_level = m_tdata[1];
				got.busy_res = m_tdata[2];
				got.done_res = m_tdata[3];
				got.ack_ok = m_tdata[4];
				got.read_word = m_tdata[20:5];
				if (tick_levels_q.size() == 0) begin
					flag_error($sformatf("word %0d arrived with none predicted", res_idx));
				end else begin
					want = tick_levels_q.pop_front();
					check_field("scl_level", got.scl_level, want.scl_level);
					check_field("sda_level", got.sda_level, want.sda_level);
					check_field("busy_res", got.busy_res, want.busy_res);
					check_field("done_res", got.done_res, want.done_res);
					check_field("ack_ok", got.ack_ok, want.ack_ok);
					check_field("read_word", got.read_word, want.read_word);
				end
				res_idx++;
			end
			// input words into the predictor, with the settings before this edge
			if (s_tvalid && s_tready) begin
				t_in.opcode = s_tuser;
				t_in.reg_address = s_tdata[15:0];
				t_in.write_value = s_tdata[31:16];
				t_in.sda_sample = s_tdata[32];
				tick_levels_q.push_back(advance_bus(t_in));
			end
			// register writes
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == i2cra_pkg::CFG_DEV_ADDR)
					dev_addr = cfg_data[6:0];
				else if (cfg_index == i2cra_pkg::CFG_HALF_PER)
					half_per = cfg_data;
			end
			// leftovers at the end of the run
			if (end_check && !end_seen) begin
				end_seen = 1'b1;
				if (tick_levels_q.size() != 0)
					flag_error($sformatf("%0d predicted words never arrived",
						tick_levels_q.size()));
			end
		end
	end

endmodule

>>> tb/tb_top.sv
// testbench top for the i2c register access master: stimulus, flow control and verdict
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int BUSY_BIT = 2;
	localparam int DONE_BIT = 3;
	localparam int CYCLE_LIMIT = 100000;
	localparam int NOISY_TICKS = 100;

	// how the data line answers during a transaction
	typedef enum int {SDA_LOW, SDA_MOSTLY_LOW, SDA_RANDOM, SDA_HIGH} sda_mode_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        end_check;
	int          fail_count;

	int          sent_cnt;
	int          recv_cnt;
	int          done_cnt;
	logic        last_busy;
	logic        quiet;
	sda_mode_t   sda_mode;
	int          stall_left;
	int          cycle_cnt;

	i2c_register_access_master dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	i2cra_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.end_check  (end_check),
		.fail_count (fail_count)
	);

	// clock
	always #5 clk = ~clk;

	// output side backpressure in short bursts
	always @(negedge clk) begin
		if (quiet || !arst_n) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// track output words for pacing the stimulus
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_cnt <= 0;
			done_cnt <= 0;
			last_busy <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			recv_cnt <= recv_cnt + 1;
			last_busy <= m_tdata[BUSY_BIT];
			if (m_tdata[DONE_BIT])
				done_cnt <= done_cnt + 1;
		end
	end

	// run time guard
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("** i2c_register_access_master: FAILED **");
		$finish;
	end

	function automatic logic sda_bit();
		case (sda_mode)
			SDA_LOW:        return 1'b0;
			SDA_MOSTLY_LOW: return ($urandom_range(0, 7) == 0);
			SDA_RANDOM:     return 1'($urandom_range(0, 1));
			default:        return 1'b1;
		endcase
	endfunction

	// one tick word, called and returning at a falling edge
	task automatic send_tick(logic [1:0] op, logic [15:0] addr, logic [15:0] val, logic sda);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 9) == 0)
			gap = $urandom_range(1, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser <= op;
		s_tdata <= {7'd0, sda, val, addr};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		sent_cnt++;
	endtask

	// tick that can start nothing
	task automatic idle_tick();
		send_tick(($urandom_range(0, 3) == 0) ? OP_UNUSED : i2cra_pkg::OP_TICK,
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), sda_bit());
	endtask

	// tick with any opcode, commands here land while busy
	task automatic noisy_tick();
		logic [1:0] op;
		op = 2'($urandom_range(0, 3));
		send_tick(op, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			sda_bit());
	endtask

	// one command, then ticks until its done word shows up
	task automatic run_cmd(logic [1:0] op, logic [15:0] addr, logic [15:0] val,
			sda_mode_t mode, logic noisy);
		int start;
		int ticks;
		sda_mode = mode;
		start = done_cnt;
		ticks = 0;
		send_tick(op, addr, val, sda_bit());
		while (done_cnt == start) begin
			// noise only early on, well inside even the shortest transaction
			if (noisy && ticks < NOISY_TICKS)
				noisy_tick();
			else
				idle_tick();
			ticks++;
		end
	endtask

	// tick on until the bus is idle and every word is back
	task automatic settle();
		do begin
			while (last_busy)
				idle_tick();
			s_tvalid <= 1'b0;
			while (recv_cnt != sent_cnt)
				@(negedge clk);
		end while (last_busy);
		repeat (4) @(negedge clk);
	endtask

	// one register write, leaves the write channel valid
	task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// write the half period only
	task automatic set_half_period(logic [15:0] hp);
		cfg_write(i2cra_pkg::CFG_HALF_PER, hp);
		cfg_valid <= 1'b0;
	endtask

	// write both registers back to back
	task automatic set_config(logic [6:0] dev, logic [15:0] hp);
		cfg_write(i2cra_pkg::CFG_DEV_ADDR, {9'd0, dev});
		cfg_write(i2cra_pkg::CFG_HALF_PER, hp);
		cfg_valid <= 1'b0;
	endtask

	// stimulus and verdict
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = i2cra_pkg::OP_TICK;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = i2cra_pkg::CFG_DEV_ADDR;
		cfg_data = '0;
		end_check = 1'b0;
		sent_cnt = 0;
		quiet = 1'b0;
		sda_mode = SDA_LOW;
		stall_left = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// idle ticks at reset settings
		repeat (12) idle_tick();
		settle();

		// read at the reset device address, two tick half period, commands while busy
		set_half_period(16'd2);
		run_cmd(i2cra_pkg::OP_READ, 16'h1234, 16'habcd, SDA_RANDOM, 1'b1);
		settle();

		// zero half period acts as one, top device address, no idling to the end
		set_config(7'd127, 16'd0);
		quiet = 1'b1;
		run_cmd(i2cra_pkg::OP_WRITE, 16'h8001, 16'h7ffe, SDA_LOW, 1'b0);
		settle();

		repeat (8) @(negedge clk);
		end_check = 1'b1;
		repeat (3) @(negedge clk);
		if (fail_count == 0)
			$display("** i2c_register_access_master: PASSED **");
		else
			$display("** i2c_register_access_master: FAILED **");
		$finish;
	end

endmodule
